/* hdl/cpt_pkg.sv */
// Shared types and constants for the capture period tachometer.
package cpt_pkg;

  localparam int OVERFLOW_BITS = 16;
  localparam int STOP_TICKS    = 2;

  localparam int OP_W    = 2;
  localparam int CAP_W   = 16;
  localparam int TPP_W   = 16;
  localparam int SPEED_W = 25;
  localparam int STOP_W  = $clog2(STOP_TICKS + 1);

  // Interval = overflow_count * ticks_per_period + capture_value
  localparam int IVL_W = OVERFLOW_BITS + TPP_W;

  // Quotient of 60000000 / interval, produced one bit per cycle
  localparam int QUO_W = 26;
  localparam int CNT_W = $clog2(QUO_W);
  localparam logic [QUO_W-1:0] US_PER_MINUTE = QUO_W'(60000000);

  // floor(2 * rpm / 5) by reciprocal multiply, exact below 2^32
  localparam int SCALE_W     = QUO_W + 1;
  localparam int RECIP_W     = 32;
  localparam int SCALE_SHIFT = 34;
  localparam logic [RECIP_W-1:0] RECIP_FIFTH = 32'hCCCC_CCCD;

  localparam logic [SPEED_W-1:0]       SPEED_MAX = SPEED_W'(24000000);
  localparam logic [TPP_W-1:0]         TPP_RESET = TPP_W'(100);
  localparam logic [OVERFLOW_BITS-1:0] OVF_MAX   = {OVERFLOW_BITS{1'b1}};
  localparam logic [STOP_W-1:0]        STOP_LOAD = STOP_W'(STOP_TICKS);

  typedef enum logic [OP_W-1:0] {
    OP_PERIOD = 2'd0,
    OP_EDGE   = 2'd1,
    OP_STOP   = 2'd2,
    OP_REARM  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_SCALE,
    S_DONE
  } state_t;

endpackage

/* hdl/cpt_if.sv */
// Valid/ready channel interfaces for the tachometer input and result transactions.
interface cpt_in_if;
  import cpt_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic              running;
  logic [CAP_W-1:0]  capture_value;

  modport source (output valid, output operation, output running, output capture_value,
                  input ready);
  modport sink   (input valid, input operation, input running, input capture_value,
                  output ready);
endinterface

interface cpt_out_if;
  import cpt_pkg::*;

  logic               valid;
  logic               ready;
  logic [SPEED_W-1:0] speed;
  logic               speed_updated;

  modport source (output valid, output speed, output speed_updated, input ready);
  modport sink   (input valid, input speed, input speed_updated, output ready);
endinterface

/* hdl/capture_period_tachometer.sv */
// Capture period tachometer: interval measurement, iterative rpm divide and output register.
// Each input transaction yields exactly one result transaction. Period, stop-check, re-arm
// and all other edges are answered in the cycle after acceptance. The second capture edge
// of a measurement steps through S_MUL for the interval multiply-add, S_DIV for the shared
// restoring subtract/compare unit that forms 60000000 / interval one quotient bit at a time,
// S_SCALE for the 10/25 scaling and S_DONE to load the result register once it is free.
// The input is not ready during that sequence or while the result register is full and
// not being drained. ticks_per_period resets to 100 and is written through cfg_we/cfg_wdata.
module capture_period_tachometer (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [cpt_pkg::TPP_W-1:0]  cfg_wdata,
  cpt_in_if.sink                     in_ch,
  cpt_out_if.source                  out_ch
);
  import cpt_pkg::*;

  state_t                   state_r, state_nxt;
  logic [TPP_W-1:0]         tpp_r;
  logic                     first_edge_seen_r, first_edge_seen_nxt;
  logic                     capture_done_r, capture_done_nxt;
  logic                     period_counting_r, period_counting_nxt;
  logic [OVERFLOW_BITS-1:0] ovf_r, ovf_nxt;
  logic [SPEED_W-1:0]       speed_value_r, speed_value_nxt;
  logic [STOP_W-1:0]        stop_timeout_r, stop_timeout_nxt;
  logic [CAP_W-1:0]         cap_r, cap_nxt;
  logic [IVL_W-1:0]         ivl_r, ivl_nxt;
  logic [IVL_W-1:0]         rem_r, rem_nxt;
  logic [QUO_W-1:0]         quo_r, quo_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [SPEED_W-1:0]       out_speed_r, out_speed_nxt;
  logic                     out_updated_r, out_updated_nxt;

  logic                     out_free;
  logic                     accept;
  logic [IVL_W:0]           rem_shift;
  logic                     rem_ge;
  logic [STOP_W-1:0]        stop_dec;
  logic [SCALE_W+RECIP_W-1:0] scale_prod;

  assign out_free     = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = (state_r == S_IDLE) && out_free;
  assign accept       = in_ch.valid && in_ch.ready;

  assign out_ch.valid         = out_valid_r;
  assign out_ch.speed         = out_speed_r;
  assign out_ch.speed_updated = out_updated_r;

  // Restoring divide step on the constant dividend, MSB first
  assign rem_shift = {rem_r, US_PER_MINUTE[cnt_r]};
  assign rem_ge    = rem_shift >= {1'b0, ivl_r};
  assign stop_dec  = (stop_timeout_r != '0) ? stop_timeout_r - STOP_W'(1) : '0;
  assign scale_prod = {quo_r, 1'b0} * RECIP_FIFTH;

  always_comb begin
    state_nxt           = state_r;
    first_edge_seen_nxt = first_edge_seen_r;
    capture_done_nxt    = capture_done_r;
    period_counting_nxt = period_counting_r;
    ovf_nxt             = ovf_r;
    speed_value_nxt     = speed_value_r;
    stop_timeout_nxt    = stop_timeout_r;
    cap_nxt             = cap_r;
    ivl_nxt             = ivl_r;
    rem_nxt             = rem_r;
    quo_nxt             = quo_r;
    cnt_nxt             = cnt_r;
    out_valid_nxt       = out_valid_r && !out_ch.ready;
    out_speed_nxt       = out_speed_r;
    out_updated_nxt     = out_updated_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_valid_nxt   = 1'b1;
          out_updated_nxt = 1'b0;
          case (op_t'(in_ch.operation))
            OP_PERIOD: begin
              if (in_ch.running && period_counting_r && ovf_r != OVF_MAX) begin
                ovf_nxt = ovf_r + OVERFLOW_BITS'(1);
              end
            end
            OP_EDGE: begin
              if (!in_ch.running) begin
                ovf_nxt = '0;
              end else if (!capture_done_r) begin
                stop_timeout_nxt = STOP_LOAD;
                if (first_edge_seen_r) begin
                  capture_done_nxt    = 1'b1;
                  first_edge_seen_nxt = 1'b0;
                  period_counting_nxt = 1'b0;
                  cap_nxt             = in_ch.capture_value;
                  out_valid_nxt       = 1'b0;
                  state_nxt           = S_MUL;
                end else begin
                  ovf_nxt             = '0;
                  first_edge_seen_nxt = 1'b1;
                  period_counting_nxt = 1'b1;
                end
              end
            end
            OP_STOP: begin
              stop_timeout_nxt = stop_dec;
              if (stop_dec == '0) begin
                speed_value_nxt = '0;
              end
            end
            OP_REARM: begin
              if (capture_done_r) begin
                capture_done_nxt = 1'b0;
                ovf_nxt          = '0;
              end
            end
            default: ;
          endcase
          out_speed_nxt = speed_value_nxt;
        end
      end
      S_MUL: begin
        ivl_nxt   = IVL_W'(ovf_r * tpp_r) + IVL_W'(cap_r);
        rem_nxt   = '0;
        cnt_nxt   = CNT_W'(QUO_W - 1);
        state_nxt = S_DIV;
      end
      S_DIV: begin
        rem_nxt = rem_ge ? rem_shift[IVL_W-1:0] - ivl_r : rem_shift[IVL_W-1:0];
        quo_nxt = {quo_r[QUO_W-2:0], rem_ge};
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          state_nxt = S_SCALE;
        end
      end
      S_SCALE: begin
        // A zero interval reads as the fastest speed
        speed_value_nxt = (ivl_r == '0) ? SPEED_MAX : scale_prod[SCALE_SHIFT +: SPEED_W];
        state_nxt       = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_speed_nxt   = speed_value_r;
          out_updated_nxt = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= S_IDLE;
      tpp_r             <= TPP_RESET;
      first_edge_seen_r <= 1'b0;
      capture_done_r    <= 1'b0;
      period_counting_r <= 1'b0;
      ovf_r             <= '0;
      speed_value_r     <= '0;
      stop_timeout_r    <= '0;
      out_valid_r       <= 1'b0;
    end else begin
      state_r           <= state_nxt;
      if (cfg_we) begin
        tpp_r <= cfg_wdata;
      end
      first_edge_seen_r <= first_edge_seen_nxt;
      capture_done_r    <= capture_done_nxt;
      period_counting_r <= period_counting_nxt;
      ovf_r             <= ovf_nxt;
      speed_value_r     <= speed_value_nxt;
      stop_timeout_r    <= stop_timeout_nxt;
      out_valid_r       <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cap_r         <= cap_nxt;
    ivl_r         <= ivl_nxt;
    rem_r         <= rem_nxt;
    quo_r         <= quo_nxt;
    cnt_r         <= cnt_nxt;
    out_speed_r   <= out_speed_nxt;
    out_updated_r <= out_updated_nxt;
  end

  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ch.ready)
    else $error("input ready while a measurement is in progress");

  a_speed_range: assert property (@(posedge clk) disable iff (!rst_n)
    speed_value_r <= SPEED_MAX)
    else $error("speed beyond its maximum");

  a_timeout_range: assert property (@(posedge clk) disable iff (!rst_n)
    stop_timeout_r <= STOP_LOAD)
    else $error("stop timeout beyond its reload value");

  a_arm_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (first_edge_seen_r == period_counting_r) && !(period_counting_r && capture_done_r))
    else $error("edge tracking flags out of step");

  a_update_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_updated_r) |-> capture_done_r)
    else $error("fresh speed shown without a completed measurement");

endmodule
